[hw/rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[hw/rtl/osh64_pkg.sv]
// ----------------------------------------------------------------------------
// osh64_pkg
// Constants for the ordered sequence hash.
// ----------------------------------------------------------------------------
package osh64_pkg;

  localparam int unsigned HASH_W = 64;
  localparam int unsigned HALF_W = 32;
  localparam int unsigned LEN_W  = 32;

  localparam logic [HASH_W-1:0] LCG_MUL = 64'd6364136223846793005;
  localparam logic [HASH_W-1:0] LCG_ADD = 64'd1442695040888963407;

  localparam logic [HALF_W-1:0] LCG_MUL_LO = LCG_MUL[HALF_W-1:0];
  localparam logic [HALF_W-1:0] LCG_MUL_HI = LCG_MUL[HASH_W-1:HALF_W];

  localparam int unsigned MIX_SH_A  = 21;
  localparam int unsigned MIX_SH_B  = 37;
  localparam int unsigned MIX_SH_C  = 4;
  localparam int unsigned JOIN_SH_A = 11;
  localparam int unsigned JOIN_SH_B = 8;
  localparam int unsigned JOIN_SH_C = 19;

  localparam logic CMD_START = 1'b0;
  localparam logic CMD_ELEM  = 1'b1;

endpackage

[hw/rtl/ordered_sequence_hash_64_top.sv]
// ----------------------------------------------------------------------------
// ordered_sequence_hash_64_top
// Order-sensitive 64-bit hash over a stream of start and element words.
// ----------------------------------------------------------------------------
// A start word (cmd 0) loads the running hash with the mix of its length; an
// element word (cmd 1) mixes its 64-bit pattern and joins it into the running
// hash. Every input word yields one output word carrying the hash after it.
// Throughput is one word per cycle unless the input stalls. Each word passes
// through three register stages: one for the three 32x32 partial products of
// the LCG multiply, one for the product sum and xorshift, and the output
// register, which also holds the running hash fed back into the join. The
// input stalls only while out_stall holds a full pipe.
`include "assert_macros.svh"

module ordered_sequence_hash_64_top (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             in_cmd,
  input  logic [osh64_pkg::LEN_W-1:0]      in_seq_length,
  input  logic [osh64_pkg::HASH_W-1:0]     in_element_bits,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [osh64_pkg::HASH_W-1:0]     out_hash
);

  localparam int unsigned HW = osh64_pkg::HASH_W;
  localparam int unsigned LW = osh64_pkg::HALF_W;

  // stage 1: partial products
  logic          s1_v_r;
  logic          s1_cmd_r;
  logic [HW-1:0] s1_p0_r;
  logic [LW-1:0] s1_p1_r;
  logic [LW-1:0] s1_p2_r;

  // stage 2: mixed value
  logic          s2_v_r;
  logic          s2_cmd_r;
  logic [HW-1:0] s2_mix_r;

  // output / running hash
  logic          out_v_r;
  logic [HW-1:0] out_hash_r;

  logic s1_adv, s2_adv, out_free, in_take;

  assign out_free = !out_v_r || !out_stall;
  assign s2_adv   = s2_v_r && out_free;
  assign s1_adv   = s1_v_r && (!s2_v_r || s2_adv);
  assign in_stall = s1_v_r && !s1_adv;
  assign in_take  = in_valid && !in_stall;

  // stage 1 datapath; cross terms only need their low half
  logic [HW-1:0] src;
  logic [HW-1:0] pp0;
  logic [LW-1:0] pp1, pp2;

  always_comb begin
    if (in_cmd == osh64_pkg::CMD_START) begin
      src = {{(HW-osh64_pkg::LEN_W){1'b0}}, in_seq_length};
    end else begin
      src = in_element_bits;
    end
    pp0 = src[LW-1:0]  * osh64_pkg::LCG_MUL_LO;
    pp1 = src[LW-1:0]  * osh64_pkg::LCG_MUL_HI;
    pp2 = src[HW-1:LW] * osh64_pkg::LCG_MUL_LO;
  end

  // stage 2 datapath: product mod 2^64, add, xorshift
  logic [HW-1:0] lcg, x1, x2, x3;
  logic [LW-1:0] mid_sum;

  always_comb begin
    mid_sum = s1_p1_r + s1_p2_r;
    lcg     = s1_p0_r + {mid_sum, {LW{1'b0}}} + osh64_pkg::LCG_ADD;
    x1      = lcg ^ (lcg >> osh64_pkg::MIX_SH_A);
    x2      = x1 ^ (x1 << osh64_pkg::MIX_SH_B);
    x3      = x2 ^ (x2 >> osh64_pkg::MIX_SH_C);
  end

  // join into the running hash; t keeps the bits shifted past the half
  localparam int unsigned TW = LW + osh64_pkg::JOIN_SH_A;
  logic [LW-1:0] acc_hi, top;
  logic [TW-1:0] t1, t2;
  logic [HW-1:0] joined, hash_nxt;

  always_comb begin
    acc_hi = out_hash_r[HW-1:LW];
    t1     = {{osh64_pkg::JOIN_SH_A{1'b0}}, s2_mix_r[LW-1:0]};
    t1     = t1 ^ (t1 << osh64_pkg::JOIN_SH_A);
    t2     = t1 ^ (t1 >> osh64_pkg::JOIN_SH_B);
    top    = t2[LW-1:0] ^ acc_hi ^ (acc_hi >> osh64_pkg::JOIN_SH_C);
    joined = {top, acc_hi} ^ {out_hash_r[LW-1:0], s2_mix_r[HW-1:LW]};
    if (s2_cmd_r == osh64_pkg::CMD_START) begin
      hash_nxt = s2_mix_r;
    end else begin
      hash_nxt = joined;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r     <= 1'b0;
      s2_v_r     <= 1'b0;
      out_v_r    <= 1'b0;
      out_hash_r <= '0;
    end else begin
      if (!s1_v_r || s1_adv) begin
        s1_v_r <= in_take;
      end
      if (!s2_v_r || s2_adv) begin
        s2_v_r <= s1_adv;
      end
      if (out_free) begin
        out_v_r <= s2_adv;
      end
      if (s2_adv) begin
        out_hash_r <= hash_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_cmd_r <= in_cmd;
      s1_p0_r  <= pp0;
      s1_p1_r  <= pp1;
      s1_p2_r  <= pp2;
    end
    if (s1_adv) begin
      s2_cmd_r <= s1_cmd_r;
      s2_mix_r <= x3;
    end
  end

  assign out_valid = out_v_r;
  assign out_hash  = out_hash_r;

  `ASSERT_NEXT(a_take_fills_s1, in_valid && !in_stall, s1_v_r)
  `ASSERT_SAME(a_full_stalls, s1_v_r && s2_v_r && out_v_r && out_stall, in_stall)
  `ASSERT_NEXT(a_hash_holds, !s2_adv, $stable(out_hash_r))

endmodule

[verif/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for ordered_sequence_hash_64_top. Start and element
// words go in one at a time; a built-in hash predictor queues the expected
// running hash for each accepted word, and every output word is compared in
// order against it. Both sides idle at random.
// ----------------------------------------------------------------------------
module tb;

  typedef logic [osh64_pkg::HASH_W-1:0] hash_t;
  typedef logic [osh64_pkg::LEN_W-1:0]  len_t;

  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned ITEM_TARGET  = 600;
  localparam int unsigned PRINT_LIMIT  = 20;
  localparam hash_t       LOW_HALF     = 64'h0000_0000_FFFF_FFFF;

  logic  clk = 1'b0;
  logic  rst_n = 1'b0;
  logic  in_valid = 1'b0;
  logic  in_stall;
  logic  in_cmd = osh64_pkg::CMD_START;
  len_t  in_seq_length = '0;
  hash_t in_element_bits = '0;
  logic  out_valid;
  logic  out_stall = 1'b0;
  hash_t out_hash;

  hash_t       predicted_hash = '0;
  hash_t       expected_hashes[$];
  bit          idling_en = 1'b1;
  int unsigned words_sent = 0;
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;

  ordered_sequence_hash_64_top dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_cmd          (in_cmd),
    .in_seq_length   (in_seq_length),
    .in_element_bits (in_element_bits),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_hash        (out_hash)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ---- hash predictor ----
  function automatic hash_t lcg_xorshift(hash_t v);
    v = v * osh64_pkg::LCG_MUL + osh64_pkg::LCG_ADD;
    v ^= v >> osh64_pkg::MIX_SH_A;
    v ^= v << osh64_pkg::MIX_SH_B;
    v ^= v >> osh64_pkg::MIX_SH_C;
    return v;
  endfunction

  // t stays 64 bits wide so the left shift spill is folded back by the right shift
  function automatic hash_t join_mixed(hash_t acc, hash_t elem);
    hash_t hi, t, lowpart, top;
    hi      = acc >> osh64_pkg::HALF_W;
    t       = elem & LOW_HALF;
    lowpart = (elem >> osh64_pkg::HALF_W) | (acc << osh64_pkg::HALF_W);
    t ^= t << osh64_pkg::JOIN_SH_A;
    t ^= t >> osh64_pkg::JOIN_SH_B;
    top = (t ^ hi ^ (hi >> osh64_pkg::JOIN_SH_C)) & LOW_HALF;
    return ((top << osh64_pkg::HALF_W) | hi) ^ lowpart;
  endfunction

  function automatic hash_t random_double_bits();
    hash_t specials[8] = '{64'h0000_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFF,
                           64'h7FF0_0000_0000_0000, 64'hFFF0_0000_0000_0000,
                           64'h7FF8_0000_0000_0001, 64'h8000_0000_0000_0000,
                           64'h3FF0_0000_0000_0000, 64'h0000_0000_0000_0001};
    case ($urandom_range(9))
      7: return specials[$urandom_range(7)];
      8: return {1'($urandom_range(1)), 11'($urandom), 52'({$urandom, $urandom})};
      9: return hash_t'($urandom_range(255));
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic report_mismatch(string msg);
    if (mismatches < PRINT_LIMIT) $display("MISMATCH @%0d: %s", cycle_count, msg);
    mismatches++;
  endtask

  // ---- driver ----
  task automatic send_word(logic cmd, len_t len, hash_t bits);
    while (idling_en && $urandom_range(99) < 6) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_cmd          <= cmd;
    in_seq_length   <= len;
    in_element_bits <= bits;
    do @(posedge clk); while (in_stall);
    if (cmd == osh64_pkg::CMD_START) predicted_hash = lcg_xorshift(hash_t'(len));
    else predicted_hash = join_mixed(predicted_hash, lcg_xorshift(bits));
    expected_hashes.push_back(predicted_hash);
    words_sent++;
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_hashes.size() != 0) @(posedge clk);
  endtask

  // ---- result side ----
  always @(posedge clk) begin
    out_stall <= idling_en && ($urandom_range(99) < 6);
  end

  always @(posedge clk) begin
    hash_t exp_hash;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_hashes.size() == 0) begin
        report_mismatch($sformatf("unexpected word hash=%h", out_hash));
      end else begin
        exp_hash = expected_hashes.pop_front();
        if (out_hash !== exp_hash)
          report_mismatch($sformatf("hash got %h exp %h", out_hash, exp_hash));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("** ordered_sequence_hash_64_top: FAILED **");
      $finish;
    end
  end

  // ---- tests ----
  // must run first: the running hash is still the reset value
  task automatic test_element_before_start();
    send_word(osh64_pkg::CMD_ELEM, $urandom, 64'h0123_4567_89AB_CDEF);
    send_word(osh64_pkg::CMD_ELEM, $urandom, 64'hFFFF_FFFF_FFFF_FFFF);
  endtask

  task automatic test_length_extremes();
    send_word(osh64_pkg::CMD_START, '0, {$urandom, $urandom});
    send_word(osh64_pkg::CMD_START, '1, {$urandom, $urandom});
    send_word(osh64_pkg::CMD_START, 32'd1, {$urandom, $urandom});
  endtask

  task automatic test_element_extremes();
    send_word(osh64_pkg::CMD_START, 32'd8, '0);
    send_word(osh64_pkg::CMD_ELEM, $urandom, 64'h0000_0000_0000_0000);
    send_word(osh64_pkg::CMD_ELEM, $urandom, 64'hFFFF_FFFF_FFFF_FFFF);
    send_word(osh64_pkg::CMD_ELEM, $urandom, 64'h7FF0_0000_0000_0000);
    send_word(osh64_pkg::CMD_ELEM, $urandom, 64'hFFF8_0000_0000_0000);
    send_word(osh64_pkg::CMD_ELEM, $urandom, 64'h8000_0000_0000_0000);
    send_word(osh64_pkg::CMD_ELEM, $urandom, 64'h0000_0000_FFFF_FFFF);
    send_word(osh64_pkg::CMD_ELEM, $urandom, 64'hFFFF_FFFF_0000_0000);
    send_word(osh64_pkg::CMD_ELEM, $urandom, 64'h0000_0000_0000_0001);
  endtask

  // announced count is not enforced: too many, then too few
  task automatic test_count_mismatch();
    send_word(osh64_pkg::CMD_START, 32'd2, '0);
    repeat (4) send_word(osh64_pkg::CMD_ELEM, '1, random_double_bits());
    send_word(osh64_pkg::CMD_START, 32'd5, '1);
    send_word(osh64_pkg::CMD_ELEM, '0, random_double_bits());
    send_word(osh64_pkg::CMD_START, 32'd3, {$urandom, $urandom});
    wait_for_results();
  endtask

  task automatic test_back_to_back();
    idling_en = 1'b0;
    send_word(osh64_pkg::CMD_START, $urandom_range(64), {$urandom, $urandom});
    repeat (80) send_word(osh64_pkg::CMD_ELEM, $urandom, random_double_bits());
    idling_en = 1'b1;
  endtask

  task automatic test_random_sequences();
    len_t len;
    int   n_elems;
    bit   paused = 1'b0;
    while (words_sent < ITEM_TARGET - 40) begin
      if (!paused && words_sent > ITEM_TARGET / 2) begin
        wait_for_results();
        paused = 1'b1;
      end
      len = ($urandom_range(19) == 0) ? len_t'($urandom) : len_t'($urandom_range(12));
      n_elems = (len > 12) ? $urandom_range(12) : int'(len);
      if ($urandom_range(6) == 0) n_elems = $urandom_range(14);
      send_word(osh64_pkg::CMD_START, len, {$urandom, $urandom});
      repeat (n_elems) send_word(osh64_pkg::CMD_ELEM, $urandom, random_double_bits());
    end
  endtask

  task automatic test_stray_words();
    repeat (40) begin
      if ($urandom_range(3) == 0)
        send_word(osh64_pkg::CMD_START, $urandom, {$urandom, $urandom});
      else send_word(osh64_pkg::CMD_ELEM, $urandom, random_double_bits());
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_element_before_start();
    test_length_extremes();
    test_element_extremes();
    test_count_mismatch();
    test_back_to_back();
    test_random_sequences();
    test_stray_words();
    wait_for_results();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("** ordered_sequence_hash_64_top: PASSED **");
    end else begin
      $display("** ordered_sequence_hash_64_top: FAILED **");
    end
    $finish;
  end

endmodule
